// File: hdl/nmf_pkg.sv
// ----------------------------------------------------------------------------
// nmf_pkg
// Shared constants, codes and fixed-point helpers for the NMF SGD update block.
// ----------------------------------------------------------------------------
package nmf_pkg;

  localparam int ROWS      = 256;
  localparam int COLS      = 1024;
  localparam int RANK      = 32;
  localparam int ROW_AW    = $clog2(ROWS);
  localparam int COL_AW    = $clog2(COLS);
  localparam int COMP_W    = $clog2(RANK);
  localparam int WF_DEPTH  = ROWS * RANK;
  localparam int HF_DEPTH  = COLS * RANK;
  localparam int WF_AW     = $clog2(WF_DEPTH);
  localparam int HF_AW     = $clog2(HF_DEPTH);
  localparam int RANK_W    = 6;
  localparam int WIDE_W    = 50;

  typedef enum logic [2:0] {
    OP_UPDATE = 3'd0,
    OP_WR_ROW = 3'd1,
    OP_WR_COL = 3'd2,
    OP_RD_ROW = 3'd3,
    OP_RD_COL = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_LEARN_RATE = 2'd0,
    REG_REG_WEIGHT = 2'd1,
    REG_RANK       = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } sat_t;

  function automatic sat_t sat32(input logic signed [WIDE_W-1:0] x);
    sat_t s;
    if (x > $signed(WIDE_W'(64'sh7FFF_FFFF))) begin
      s.val  = 32'sh7FFF_FFFF;
      s.clip = 1'b1;
    end else if (x < -$signed(WIDE_W'(64'sh8000_0000))) begin
      s.val  = 32'sh8000_0000;
      s.clip = 1'b1;
    end else begin
      s.val  = x[31:0];
      s.clip = 1'b0;
    end
    return s;
  endfunction

endpackage

// File: hdl/nmf_ram.sv
// ----------------------------------------------------------------------------
// nmf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/nmf_sgd_update_top.sv
// ----------------------------------------------------------------------------
// nmf_sgd_update_top
// One SGD step of nonnegative matrix factorization per nonzero, Q16.16, with
// row and column factor stores, plus single-entry factor loads and reads.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  in      | sink      | in_valid/in_stall  | op, row, col, component, value
//  out     | source    | out_valid/out_stall| result_value, saturated
//  cfg     | sink      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  Update: a dot product over k components (k = active rank), the residual, then
//  a factor update per component, through the one shared 33x33 multiplier.
//  One word at a time: in_stall is high from accept until the result is taken.
//  Factor stores are not cleared by reset; rst clears control, config and outputs.
// ----------------------------------------------------------------------------
module nmf_sgd_update_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [7:0]  row,
  input  logic [9:0]  col,
  input  logic [4:0]  component,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_value,
  output logic        saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_WAIT, ST_RD_DATA,
    ST_DOT_RD, ST_DOT_MUL, ST_DOT_ACC, ST_RES,
    ST_UPD_RD, ST_UPD_M1, ST_UPD_M2, ST_UPD_T, ST_UPD_M3, ST_UPD_WN,
    ST_UPD_M4, ST_UPD_M5, ST_UPD_U, ST_UPD_M6, ST_UPD_HN,
    ST_OUT
  } state_t;

  state_t state;

  logic [16:0] learn_rate;
  logic [16:0] reg_weight;
  logic [5:0]  rank_in_use;

  logic [2:0]                       op_r;
  logic [nmf_pkg::ROW_AW-1:0]       row_r;
  logic [nmf_pkg::COL_AW-1:0]       col_r;
  logic [nmf_pkg::COMP_W-1:0]       idx;
  logic [nmf_pkg::RANK_W-1:0]       k_r;
  logic signed [31:0]               val_r;
  logic signed [31:0]               acc;
  logic signed [31:0]               res;
  logic signed [31:0]               w_r;
  logic signed [31:0]               h_r;
  logic signed [31:0]               tmp;
  logic signed [31:0]               wn_r;
  logic signed [nmf_pkg::WIDE_W-1:0] p1;
  logic signed [65:0]               prod;
  logic                             clip;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [nmf_pkg::WIDE_W-1:0] q;
  logic [nmf_pkg::RANK_W-1:0]       k_in;
  logic                             last;

  logic                       wf_we;
  logic                       hf_we;
  logic [nmf_pkg::WF_AW-1:0]  wf_waddr;
  logic [nmf_pkg::HF_AW-1:0]  hf_waddr;
  logic [nmf_pkg::WF_AW-1:0]  wf_raddr;
  logic [nmf_pkg::HF_AW-1:0]  hf_raddr;
  logic [31:0]                wf_wdata;
  logic [31:0]                hf_wdata;
  logic [31:0]                wf_rdata;
  logic [31:0]                hf_rdata;

  nmf_pkg::sat_t s_acc, s_res, s_t, s_wn, s_u, s_hn;
  logic signed [31:0] wn_c;
  logic signed [31:0] hn_c;

  nmf_ram #(.WIDTH(32), .DEPTH(nmf_pkg::WF_DEPTH)) u_wf (
    .clk(clk), .we(wf_we), .waddr(wf_waddr), .wdata(wf_wdata),
    .raddr(wf_raddr), .rdata(wf_rdata)
  );

  nmf_ram #(.WIDTH(32), .DEPTH(nmf_pkg::HF_DEPTH)) u_hf (
    .clk(clk), .we(hf_we), .waddr(hf_waddr), .wdata(hf_wdata),
    .raddr(hf_raddr), .rdata(hf_rdata)
  );

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state == ST_OUT);
  assign k_in = (rank_in_use > nmf_pkg::RANK_W'(nmf_pkg::RANK))
              ? nmf_pkg::RANK_W'(nmf_pkg::RANK) : rank_in_use;
  assign last = ({1'b0, idx} == (k_r - nmf_pkg::RANK_W'(1)));
  assign q = prod[nmf_pkg::WIDE_W+15:16];

  always_comb begin
    wf_raddr = (state == ST_IDLE) ? {row[nmf_pkg::ROW_AW-1:0], component}
                                  : {row_r, idx};
    hf_raddr = (state == ST_IDLE) ? {col[nmf_pkg::COL_AW-1:0], component}
                                  : {col_r, idx};
    wf_we    = 1'b0;
    hf_we    = 1'b0;
    wf_waddr = {row_r, idx};
    hf_waddr = {col_r, idx};
    wf_wdata = wn_r;
    hf_wdata = hn_c;
    if (state == ST_IDLE) begin
      wf_waddr = {row[nmf_pkg::ROW_AW-1:0], component};
      hf_waddr = {col[nmf_pkg::COL_AW-1:0], component};
      wf_wdata = value;
      hf_wdata = value;
      wf_we    = in_valid && (op == nmf_pkg::OP_WR_ROW);
      hf_we    = in_valid && (op == nmf_pkg::OP_WR_COL);
    end else if (state == ST_UPD_HN) begin
      wf_we = 1'b1;
      hf_we = 1'b1;
    end
  end

  always_comb begin
    unique case (state)
      ST_DOT_MUL: begin
        mul_a = 33'(signed'(wf_rdata));
        mul_b = 33'(signed'(hf_rdata));
      end
      ST_UPD_M1: begin
        mul_a = 33'(res);
        mul_b = 33'(signed'(hf_rdata));
      end
      ST_UPD_M2: begin
        mul_a = signed'({16'b0, reg_weight});
        mul_b = 33'(w_r);
      end
      ST_UPD_M3, ST_UPD_M6: begin
        mul_a = signed'({16'b0, learn_rate});
        mul_b = 33'(tmp);
      end
      ST_UPD_M4: begin
        mul_a = 33'(res);
        mul_b = 33'(wn_r);
      end
      ST_UPD_M5: begin
        mul_a = signed'({16'b0, reg_weight});
        mul_b = 33'(h_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    s_acc = nmf_pkg::sat32(nmf_pkg::WIDE_W'(acc) + q);
    s_res = nmf_pkg::sat32(nmf_pkg::WIDE_W'(val_r) - nmf_pkg::WIDE_W'(acc));
    s_t   = nmf_pkg::sat32(p1 - q);
    s_wn  = nmf_pkg::sat32(nmf_pkg::WIDE_W'(w_r) + q);
    s_u   = s_t;
    s_hn  = nmf_pkg::sat32(nmf_pkg::WIDE_W'(h_r) + q);
    wn_c  = s_wn.val[31] ? 32'sd0 : s_wn.val;
    hn_c  = s_hn.val[31] ? 32'sd0 : s_hn.val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      learn_rate   <= 17'd655;
      reg_weight   <= 17'd0;
      rank_in_use  <= 6'd32;
      result_value <= '0;
      saturated    <= 1'b0;
      clip         <= 1'b0;
      idx          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          nmf_pkg::REG_LEARN_RATE: learn_rate  <= cfg_data;
          nmf_pkg::REG_REG_WEIGHT: reg_weight  <= cfg_data;
          nmf_pkg::REG_RANK:       rank_in_use <= cfg_data[5:0];
          default: ;
        endcase
      end
      prod <= mul_a * mul_b;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_r         <= op;
            row_r        <= row[nmf_pkg::ROW_AW-1:0];
            col_r        <= col[nmf_pkg::COL_AW-1:0];
            val_r        <= value;
            k_r          <= k_in;
            acc          <= '0;
            clip         <= 1'b0;
            // reads keep the store address on the entry until its data lands
            idx          <= (op == nmf_pkg::OP_UPDATE) ? nmf_pkg::COMP_W'(0) : component;
            result_value <= '0;
            saturated    <= 1'b0;
            if (op == nmf_pkg::OP_UPDATE) begin
              state <= (k_in == '0) ? ST_RES : ST_DOT_RD;
            end else if (op == nmf_pkg::OP_RD_ROW || op == nmf_pkg::OP_RD_COL) begin
              state <= ST_RD_WAIT;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_RD_WAIT: state <= ST_RD_DATA;
        ST_RD_DATA: begin
          result_value <= (op_r == nmf_pkg::OP_RD_ROW) ? wf_rdata : hf_rdata;
          state        <= ST_OUT;
        end
        ST_DOT_RD:  state <= ST_DOT_MUL;
        ST_DOT_MUL: state <= ST_DOT_ACC;
        ST_DOT_ACC: begin
          acc  <= s_acc.val;
          clip <= clip | s_acc.clip;
          idx  <= idx + 1'b1;
          state <= last ? ST_RES : ST_DOT_RD;
        end
        ST_RES: begin
          res  <= s_res.val;
          clip <= clip | s_res.clip;
          idx  <= '0;
          state <= (k_r == '0) ? ST_OUT : ST_UPD_RD;
          result_value <= s_res.val;
          saturated    <= clip | s_res.clip;
        end
        ST_UPD_RD: state <= ST_UPD_M1;
        ST_UPD_M1: begin
          w_r   <= wf_rdata;
          h_r   <= hf_rdata;
          state <= ST_UPD_M2;
        end
        ST_UPD_M2: begin
          p1    <= q;
          state <= ST_UPD_T;
        end
        ST_UPD_T: begin
          tmp   <= s_t.val;
          clip  <= clip | s_t.clip;
          state <= ST_UPD_M3;
        end
        ST_UPD_M3: state <= ST_UPD_WN;
        ST_UPD_WN: begin
          wn_r  <= wn_c;
          clip  <= clip | s_wn.clip;
          state <= ST_UPD_M4;
        end
        ST_UPD_M4: state <= ST_UPD_M5;
        ST_UPD_M5: begin
          p1    <= q;
          state <= ST_UPD_U;
        end
        ST_UPD_U: begin
          tmp   <= s_u.val;
          clip  <= clip | s_u.clip;
          state <= ST_UPD_M6;
        end
        ST_UPD_M6: state <= ST_UPD_HN;
        ST_UPD_HN: begin
          clip <= clip | s_hn.clip;
          idx  <= idx + 1'b1;
          if (last) begin
            saturated <= clip | s_hn.clip;
            state     <= ST_OUT;
          end else begin
            state <= ST_UPD_RD;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");

  a_idx_in_rank: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD_HN || state == ST_DOT_ACC) |-> ({1'b0, idx} < k_r))
    else $error("component index beyond active rank");

  a_write_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (op == nmf_pkg::OP_WR_ROW || op == nmf_pkg::OP_WR_COL))
    |=> (out_valid && result_value == '0 && !saturated))
    else $error("factor write did not return zero");

  a_store_write_phase: assert property (@(posedge clk) disable iff (rst)
    (wf_we && in_stall) |-> (state == ST_UPD_HN && hf_we))
    else $error("row store written outside update write-back");

endmodule
